FILE: hdl/flash_log_page_tracker_core_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef FLASH_LOG_PAGE_TRACKER_CORE_MACROS_SVH
`define FLASH_LOG_PAGE_TRACKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define FLPT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define FLPT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FLPT_ASSERT(name, clk, rst_n, prop, msg)
`define FLPT_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: hdl/flpt_pkg.sv
package flpt_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned PageW    = 12;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned BlkW     = 12;
  localparam int unsigned PinW     = 13;
  localparam int unsigned PpbW     = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  // write position can reach pages_in_use - 1, which needs the full register width
  localparam int unsigned WpW      = 13;
  // block * pages_per_block + pages_per_block - 1 stays below 2**22
  localparam int unsigned ClrAddrW = 22;

  localparam logic [CmdW-1:0] CmdScan    = 3'd0;
  localparam logic [CmdW-1:0] CmdFinish  = 3'd1;
  localparam logic [CmdW-1:0] CmdMark    = 3'd2;
  localparam logic [CmdW-1:0] CmdClear   = 3'd3;
  localparam logic [CmdW-1:0] CmdAdvance = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgPagesInUse   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPagesPerBlock = 1'b1;

  localparam logic [SeqW-1:0] ErasedWord = 32'hffff_ffff;
  localparam logic [SeqW-1:0] MagicV1    = 32'h5d00_5d00;
  localparam logic [SeqW-1:0] MagicV2    = 32'h5d00_5e00;
  localparam logic [SeqW-1:0] SeqLowWin  = 32'h4000_0000;
  localparam logic [SeqW-1:0] SeqHighWin = 32'hc000_0000;
  localparam logic [SeqW-1:0] SeqHalf    = 32'h8000_0000;

  localparam logic [PinW-1:0] PinReset = 13'd4096;
  localparam logic [PinW-1:0] PinMin   = 13'd2;
  localparam logic [PpbW-1:0] PpbReset = 11'd16;
  localparam logic [PpbW-1:0] PpbMin   = 11'd1;
  localparam logic [PpbW-1:0] PpbMax   = 11'd1024;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [PageW-1:0] page;
    logic [SeqW-1:0]  seq;
    logic [SeqW-1:0]  magic;
    logic             bad_block;
    logic             read_ok;
    logic [BlkW-1:0]  block;
  } flpt_in_t;

  typedef struct packed {
    logic [PageW-1:0] next_page;
    logic [SeqW-1:0]  next_count;
    logic             erase_needed;
  } flpt_out_t;

endpackage

FILE: hdl/flpt_stream_if.sv
interface flpt_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

FILE: hdl/flash_log_page_tracker_core.sv
// Channel   Dir  Payload      Transfer
// in_i      in   flpt_in_t    in_i.valid & in_i.ready
// out_o     out  flpt_out_t   out_o.valid & out_o.ready
// cfg       in   idx, data    cfg_we_i
//
// Scan and mark write the used map in the accept cycle. For every command
// except clear block, the result register is then loaded from the registered
// map read of the new write page once out_o can take it. Clear block walks
// its pages, one map write per cycle, pages_per_block saturated to 1..1024.
// After reset the map is swept to zero with in_i.ready low.
// While a result is stalled on out_o, one new command is taken; its result
// then holds the tracker in its result state.
`include "flash_log_page_tracker_core_macros.svh"

module flash_log_page_tracker_core
  import flpt_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  flpt_stream_if.sink         in_i,
  flpt_stream_if.source       out_o
);

  localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam logic [ClrAddrW-1:0] MaxPgClr = ClrAddrW'(MAX_PAGES);
  localparam logic [PinW-1:0] PgCap = (MAX_PAGES > 8191) ? 13'd8191 : PinW'(MAX_PAGES);

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_WALK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [PinW-1:0]     pin_q;
  logic [PpbW-1:0]     ppb_q;
  logic [WpW-1:0]      wp_q, wp_d;
  logic [SeqW-1:0]     cnt_q, cnt_d;
  logic [SeqW-1:0]     nseq_q, nseq_d;
  logic [PageW-1:0]    npage_q, npage_d;
  logic [ClrAddrW-1:0] clr_addr_q, clr_addr_d;
  logic [PpbW-1:0]     clr_left_q, clr_left_d;
  logic                out_valid_q, out_valid_d;
  flpt_out_t           out_q;

  // used map
  logic                mem_q [MAX_PAGES];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_wdata;
  logic [AW-1:0]       rd_addr;
  logic                rd_q;
  logic                rd_ok_q;
  logic                fwd_hit_q;
  logic                fwd_val_q;
  logic [ClrAddrW-1:0] wp_ext;
  logic                used_now;

  logic [PinW-1:0]     eff_pages;
  logic [PpbW-1:0]     eff_ppb;
  logic                in_fire;
  logic                out_fire;
  logic                load_out;
  logic                scan_ok;
  logic                magic_ok;
  logic                take;
  logic [ClrAddrW-1:0] page_ext;
  logic [ClrAddrW-1:0] wp_q_ext;
  logic [22:0]         clr_start;
  logic [WpW-1:0]      fin_wp;
  logic [SeqW-1:0]     fin_cnt;
  flpt_in_t            req;

  function automatic logic [WpW-1:0] wp_step(input logic [WpW-1:0] wp,
                                             input logic [PinW-1:0] lim);
    logic [WpW:0] nx;
    nx = {1'b0, wp} + 1'b1;
    return (nx >= {1'b0, lim}) ? '0 : nx[WpW-1:0];
  endfunction

  function automatic logic [SeqW-1:0] cnt_step(input logic [SeqW-1:0] c);
    logic [SeqW-1:0] nx;
    nx = c + 1'b1;
    return (nx == ErasedWord) ? '0 : nx;
  endfunction

  assign req      = in_i.data;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign eff_pages = (pin_q < PinMin) ? PinMin : ((pin_q > PgCap) ? PgCap : pin_q);
  assign eff_ppb   = (ppb_q < PpbMin) ? PpbMin : ((ppb_q > PpbMax) ? PpbMax : ppb_q);

  assign page_ext  = ClrAddrW'(req.page);
  assign wp_q_ext  = ClrAddrW'(wp_q);
  assign clr_start = 23'(req.block) * 23'(eff_ppb);

  assign scan_ok  = ({1'b0, req.page} < eff_pages) && (page_ext < MaxPgClr) && !req.bad_block;
  assign magic_ok = (req.magic == MagicV1) || (req.magic == MagicV2);
  assign take = (nseq_q == ErasedWord)
             || ((req.seq < SeqLowWin) && (nseq_q > SeqHighWin))
             || ((req.seq > nseq_q) && (req.seq < SeqHighWin))
             || ((req.seq > nseq_q) && (req.seq > SeqHighWin) && (nseq_q > SeqHalf));

  assign fin_wp  = (nseq_q == ErasedWord) ? (eff_pages - 1'b1) : WpW'(npage_q);
  assign fin_cnt = (nseq_q == ErasedWord) ? '0 : nseq_q;

  assign load_out = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    nseq_d      = nseq_q;
    npage_d     = npage_q;
    clr_addr_d  = clr_addr_q;
    clr_left_d  = clr_left_q;
    mem_we      = 1'b0;
    mem_waddr   = page_ext[AW-1:0];
    mem_wdata   = 1'b0;
    out_valid_d = out_valid_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q[AW-1:0];
        if (clr_addr_q == MaxPgClr - 1'b1) begin
          clr_addr_d = '0;
          state_d    = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_RESP;
          unique case (req.cmd)
            CmdScan: begin
              if (scan_ok) begin
                mem_we    = 1'b1;
                mem_waddr = page_ext[AW-1:0];
                mem_wdata = !(req.read_ok && (req.seq == ErasedWord)
                              && (req.magic == ErasedWord));
                if (req.read_ok && (req.seq != ErasedWord) && magic_ok && take) begin
                  nseq_d  = req.seq;
                  npage_d = req.page;
                end
              end
            end
            CmdFinish: begin
              wp_d    = wp_step(fin_wp, eff_pages);
              cnt_d   = cnt_step(fin_cnt);
              nseq_d  = ErasedWord;
              npage_d = '0;
            end
            CmdMark: begin
              mem_we    = (wp_q_ext < MaxPgClr);
              mem_waddr = wp_q_ext[AW-1:0];
              mem_wdata = 1'b1;
            end
            CmdClear: begin
              clr_addr_d = clr_start[ClrAddrW-1:0];
              clr_left_d = eff_ppb;
              state_d    = S_WALK;
            end
            CmdAdvance: begin
              wp_d  = wp_step(wp_q, eff_pages);
              cnt_d = cnt_step(cnt_q);
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        // drop pages that fall past the end of the map
        mem_we     = (clr_addr_q < MaxPgClr);
        mem_waddr  = clr_addr_q[AW-1:0];
        clr_addr_d = clr_addr_q + 1'b1;
        clr_left_d = clr_left_q - 1'b1;
        if (clr_left_q == PpbMin) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // read the page the next result reports, with this cycle's write forwarded
  assign wp_ext  = ClrAddrW'(wp_d);
  assign rd_addr = wp_ext[AW-1:0];
  assign used_now = rd_ok_q && (fwd_hit_q ? fwd_val_q : rd_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q      <= mem_q[rd_addr];
    rd_ok_q   <= (wp_ext < MaxPgClr);
    fwd_hit_q <= mem_we && (mem_waddr == rd_addr);
    fwd_val_q <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.next_page    <= wp_q[PageW-1:0];
      out_q.next_count   <= cnt_q;
      out_q.erase_needed <= used_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      pin_q       <= PinReset;
      ppb_q       <= PpbReset;
      wp_q        <= '0;
      cnt_q       <= '0;
      nseq_q      <= ErasedWord;
      npage_q     <= '0;
      clr_addr_q  <= '0;
      clr_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      nseq_q      <= nseq_d;
      npage_q     <= npage_d;
      clr_addr_q  <= clr_addr_d;
      clr_left_q  <= clr_left_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPagesInUse:    pin_q <= cfg_data_i[PinW-1:0];
          CfgPagesPerBlock: ppb_q <= cfg_data_i[PpbW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  `FLPT_ASSERT(a_out_from_resp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_RESP), "result raised outside result state")
  `FLPT_ASSERT(a_resp_holds_pos, clk_i, rst_ni, (state_q == S_RESP) && $past(state_q == S_RESP) && $past(rst_ni) |-> $stable(wp_q) && $stable(cnt_q), "write position moved while result pending")
  `FLPT_ASSERT(a_idle_write_needs_cmd, clk_i, rst_ni, mem_we && (state_q == S_IDLE) |-> in_fire, "map written without a command")
  `FLPT_ASSERT(a_walk_count, clk_i, rst_ni, (state_q == S_WALK) |-> (clr_left_q != '0), "block walk with no pages left")
  `FLPT_ASSERT_ALWAYS(a_no_accept_in_sweep, clk_i, (state_q == S_CLR) |-> !in_fire && !out_valid_q, "transfer during map sweep")

endmodule
